// ===== hw/rtl/lfr_pkg.sv =====
package lfr_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  localparam int LEN_W  = 11;
  localparam int OFF_W  = 11;
  localparam int CFG_W  = 11;
  localparam int HL_W   = 6;

  localparam logic [LEN_W-1:0] LINK_HDR        = 11'd14;
  localparam logic [LEN_W-1:0] IP_MIN_FRAME    = 11'd34;
  localparam logic [HL_W-1:0]  IP_MIN_HDR      = 6'd20;
  localparam logic [HL_W-1:0]  IP_CSUM_HI_OFS  = 6'd10;
  localparam logic [HL_W-1:0]  IP_CSUM_LO_OFS  = 6'd11;
  localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 11'd1500;

  typedef enum logic [1:0] {
    MODE_WR_BYTE = 2'd0,
    MODE_COMMIT  = 2'd1,
    MODE_RD_BYTE = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IGNORED = 3'd1,
    ST_SHORT   = 3'd2,
    ST_LONG    = 3'd3,
    ST_BAD_IP  = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    st_load;
    status_t st_code;
    logic    wr_byte;
    logic    rd_data;
    logic    rd_ihl;
    logic    start_sum;
    logic    sum_step;
    logic    wr_hi;
    logic    wr_lo;
    logic    commit;
    logic    release_slot;
    logic    cap_rbyte;
    logic    load_out;
  } lfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t   mode;
    logic    ipv4;
    status_t early;
    logic    off_ok;
    logic    hdr_ok;
    logic    sum_last;
    logic    out_free;
  } lfr_sts_t;

endpackage

// ===== hw/rtl/lfr_ctrl.sv =====
module lfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lfr_pkg::lfr_sts_t sts,
  output lfr_pkg::lfr_cmd_t cmd
);
  import lfr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECIDE  = 8'b0000_0010,
    S_RD_WAIT = 8'b0000_0100,
    S_IHL_CHK = 8'b0000_1000,
    S_SUM     = 8'b0001_0000,
    S_WR_HI   = 8'b0010_0000,
    S_WR_LO   = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st_code = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.st_load = 1'b1;
        cmd.st_code = sts.early;
        state_nxt   = S_DONE;
        case (sts.mode)
          MODE_WR_BYTE: begin
            cmd.wr_byte = (sts.early == ST_OK) && sts.off_ok;
          end
          MODE_COMMIT: begin
            if (sts.early == ST_OK) begin
              if (sts.ipv4) begin
                cmd.rd_ihl = 1'b1;
                state_nxt  = S_IHL_CHK;
              end else begin
                cmd.commit = 1'b1;
              end
            end
          end
          MODE_RD_BYTE: begin
            if ((sts.early == ST_OK) && sts.off_ok) begin
              cmd.rd_data = 1'b1;
              state_nxt   = S_RD_WAIT;
            end
          end
          MODE_RELEASE: begin
            cmd.release_slot = (sts.early == ST_OK);
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.cap_rbyte = 1'b1;
        state_nxt     = S_DONE;
      end
      S_IHL_CHK: begin
        if (sts.hdr_ok) begin
          cmd.start_sum = 1'b1;
          state_nxt     = S_SUM;
        end else begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_BAD_IP;
          state_nxt   = S_DONE;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_nxt = S_WR_HI;
        end
      end
      S_WR_HI: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_WR_LO;
      end
      S_WR_LO: begin
        cmd.wr_lo  = 1'b1;
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_sum_is_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (sts.ipv4 && (sts.mode == MODE_COMMIT)))
    else $error("checksum walk outside an IPv4 commit");

  a_done_after_wr_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_LO) |=> (state_r == S_DONE))
    else $error("commit did not finish after checksum write");

  a_latch_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |-> (state_r == S_IDLE) && !cmd.load_out)
    else $error("transaction latched outside idle");

endmodule

// ===== hw/rtl/lfr_dp.sv =====
module lfr_dp #(
  parameter int RING_DEPTH = 8,
  parameter int BUF_BYTES  = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lfr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [lfr_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lfr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [lfr_pkg::CFG_W-1:0]       cfg_wr_data,
  input  lfr_pkg::lfr_cmd_t               cmd,
  output lfr_pkg::lfr_sts_t               sts
);
  import lfr_pkg::*;

  localparam int SLOT_W    = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = RING_DEPTH * BUF_BYTES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CMP_W     = ($clog2(BUF_BYTES + 1) > 12) ? $clog2(BUF_BYTES + 1) : 12;
  localparam logic [ADDR_W-1:0] BUF_A     = ADDR_W'(BUF_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

  // Latched transaction fields.
  mode_t              mode_r;
  logic [OFF_W-1:0]   off_r;
  logic [7:0]         wb_r;
  logic [LEN_W-1:0]   len_r;
  logic               ipv4_r;

  logic [CFG_W-1:0]   max_payload_r;
  logic [RING_DEPTH-1:0] slot_full_r;
  logic [LEN_W-1:0]   slot_len_r [RING_DEPTH];
  logic [SLOT_W-1:0]  ws_r, rs_r;

  logic [7:0]         mem [MEM_DEPTH];
  logic [7:0]         rdata_r;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [7:0]         mem_wdata;

  logic [HL_W-1:0]    hl_r, byte_idx_r;
  logic [7:0]         hi_r;
  logic [15:0]        sum_r;
  logic [7:0]         rbyte_r;
  status_t            status_r, early;
  logic               irq_r;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [ADDR_W-1:0]  tx_base, rx_base, ip_base;
  logic [HL_W-1:0]    hl_new;
  logic [7:0]         sum_byte;
  logic [16:0]        sum_add;
  logic               off_ok, too_long;

  assign tx_base = ADDR_W'(ADDR_W'(ws_r) * BUF_A);
  assign rx_base = ADDR_W'(ADDR_W'(rs_r) * BUF_A);
  assign ip_base = tx_base + ADDR_W'(LINK_HDR);

  assign off_ok   = CMP_W'(off_r) < CMP_W'(BUF_BYTES);
  assign too_long = ({1'b0, len_r} > ({1'b0, max_payload_r} + {1'b0, LINK_HDR}))
                 || (CMP_W'(len_r) > CMP_W'(BUF_BYTES));

  always_comb begin
    early = ST_OK;
    case (mode_r)
      MODE_WR_BYTE: begin
        if (slot_full_r[ws_r]) early = ST_IGNORED;
      end
      MODE_COMMIT: begin
        if (len_r < LINK_HDR)                  early = ST_SHORT;
        else if (too_long)                     early = ST_LONG;
        else if (slot_full_r[ws_r])            early = ST_IGNORED;
        else if (ipv4_r && len_r < IP_MIN_FRAME) early = ST_BAD_IP;
      end
      MODE_RD_BYTE, MODE_RELEASE: begin
        if (!slot_full_r[rs_r]) early = ST_IGNORED;
      end
      default: early = ST_OK;
    endcase
  end

  // IHL is in the low nibble of the first IP header byte.
  assign hl_new = {rdata_r[3:0], 2'b00};

  assign sts.mode     = mode_r;
  assign sts.ipv4     = ipv4_r;
  assign sts.early    = early;
  assign sts.off_ok   = off_ok;
  assign sts.hdr_ok   = (hl_new >= IP_MIN_HDR) && (len_r >= (LINK_HDR + LEN_W'(hl_new)));
  assign sts.sum_last = (byte_idx_r == hl_r - 6'd1);
  assign sts.out_free = !out_valid_r || out_tready;

  // The checksum field itself counts as zero while summing.
  assign sum_byte = ((byte_idx_r == IP_CSUM_HI_OFS) || (byte_idx_r == IP_CSUM_LO_OFS))
                  ? 8'd0 : rdata_r;
  assign sum_add  = {1'b0, sum_r} + {1'b0, hi_r, sum_byte};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tx_base + ADDR_W'(off_r);
    mem_wdata = wb_r;
    if (cmd.wr_byte) begin
      mem_we = 1'b1;
    end else if (cmd.wr_hi) begin
      mem_we    = 1'b1;
      mem_waddr = ip_base + ADDR_W'(IP_CSUM_HI_OFS);
      mem_wdata = ~sum_r[15:8];
    end else if (cmd.wr_lo) begin
      mem_we    = 1'b1;
      mem_waddr = ip_base + ADDR_W'(IP_CSUM_LO_OFS);
      mem_wdata = ~sum_r[7:0];
    end
  end

  always_comb begin
    mem_re    = cmd.rd_data || cmd.rd_ihl || cmd.start_sum || cmd.sum_step;
    mem_raddr = ip_base;
    if (cmd.rd_data) begin
      mem_raddr = rx_base + ADDR_W'(off_r);
    end else if (cmd.sum_step) begin
      mem_raddr = ip_base + ADDR_W'(byte_idx_r) + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= mode_t'(in_tuser);
      off_r  <= in_tdata[10:0];
      wb_r   <= in_tdata[18:11];
      len_r  <= in_tdata[29:19];
      ipv4_r <= in_tdata[30];
    end
    if (cmd.start_sum) begin
      hl_r       <= hl_new;
      byte_idx_r <= '0;
      sum_r      <= '0;
    end else if (cmd.sum_step) begin
      byte_idx_r <= byte_idx_r + 6'd1;
      if (!byte_idx_r[0]) begin
        hi_r <= sum_byte;
      end else begin
        sum_r <= sum_add[16] ? (sum_add[15:0] + 16'd1) : sum_add[15:0];
      end
    end
    if (cmd.latch) begin
      rbyte_r <= '0;
    end else if (cmd.cap_rbyte) begin
      rbyte_r <= rdata_r;
    end
    if (cmd.st_load) status_r <= cmd.st_code;
    if (cmd.commit) slot_len_r[ws_r] <= len_r;
    if (cmd.load_out) begin
      out_data_r <= {7'd0, irq_r, status_r,
                     slot_full_r[rs_r] ? slot_len_r[rs_r] : 11'd0,
                     slot_full_r[rs_r], !slot_full_r[ws_r], rbyte_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      slot_full_r   <= '0;
      ws_r          <= '0;
      rs_r          <= '0;
      irq_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) max_payload_r <= cfg_wr_data;
      if (cmd.latch) begin
        irq_r <= 1'b0;
      end else if (cmd.commit) begin
        irq_r <= 1'b1;
      end
      if (cmd.commit) begin
        slot_full_r[ws_r] <= 1'b1;
        ws_r <= (ws_r == LAST_SLOT) ? '0 : ws_r + SLOT_W'(1);
      end
      if (cmd.release_slot) begin
        slot_full_r[rs_r] <= 1'b0;
        rs_r <= (rs_r == LAST_SLOT) ? '0 : rs_r + SLOT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_full_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.commit && !cmd.release_slot) |=> $stable(slot_full_r))
    else $error("slot full flags changed without commit or release");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !slot_full_r[ws_r])
    else $error("commit into a full slot");

  a_release_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.release_slot |-> slot_full_r[rs_r])
    else $error("release of an empty slot");

endmodule

// ===== hw/rtl/loopback_frame_ring_ipv4_checksum.sv =====
// Channel | Direction | Ports
// in      | slave     | in_tvalid, in_tready, in_tdata[31:0], in_tuser[1:0]
// out     | master    | out_tvalid, out_tready, out_tdata[31:0]
// cfg     | write     | cfg_wr_en, cfg_wr_data[10:0] (max_payload)
//
// A byte write, release, plain commit or early rejection passes S_IDLE, S_DECIDE and
// S_DONE; a byte read adds S_RD_WAIT, and an IPv4 commit failing the header check adds
// S_IHL_CHK. An IPv4 commit walks the header one byte per cycle through the single read
// port of the frame store.
// Reset (rst_n low, synchronous) empties all slots and restores max_payload.
// One transaction is in work at a time; in_tready is low meanwhile. The
// output register holds a result until taken while the next one is accepted.
module loopback_frame_ring_ipv4_checksum #(
  parameter int RING_DEPTH = 8,
  parameter int BUF_BYTES  = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // offset[10:0], write_byte[18:11], frame_length[29:19], is_ipv4[30]
  input  logic [lfr_pkg::IN_DATA_W-1:0]   in_tdata,
  // mode[1:0]
  input  logic [lfr_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_byte[7:0], tx_slot_free[8], rx_frame_ready[9], rx_length[20:10],
  // status[23:21], interrupt[24]
  output logic [lfr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [lfr_pkg::CFG_W-1:0]       cfg_wr_data
);
  import lfr_pkg::*;

  lfr_cmd_t cmd;
  lfr_sts_t sts;

  lfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfr_dp #(
    .RING_DEPTH (RING_DEPTH),
    .BUF_BYTES  (BUF_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== tb/loopback_frame_ring_ipv4_checksum_test.sv =====
`default_nettype none

module loopback_frame_ring_ipv4_checksum_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfr_pkg::*;

  localparam int RING_SLOTS = 8;
  localparam int SLOT_BYTES = 2048;
  localparam int STORE_BYTES = RING_SLOTS * SLOT_BYTES;

  typedef struct {
    mode_t      mode;
    logic [10:0] off;
    logic [7:0]  wbyte;
    logic [10:0] len;
    logic        ipv4;
  } ring_req_t;

  typedef struct {
    logic [7:0]  rbyte;
    logic        tx_free;
    logic        rx_ready;
    logic [10:0] rx_len;
    status_t     status;
    logic        irq;
  } ring_rsp_t;

  // Shadow of the frame ring. It predicts the response to every accepted
  // transaction and keeps the predictions in order until they are checked.
  class frame_ring_board;
    logic [7:0]  store [STORE_BYTES];
    bit          written [STORE_BYTES];
    bit          full [RING_SLOTS];
    logic [10:0] slot_len [RING_SLOTS];
    int unsigned wslot;
    int unsigned rslot;
    int unsigned max_pay;
    ring_rsp_t   pending [$];
    int          errors;
    int          n_items;
    int          n_checked;
    int          n_commits;
    int          n_cksum;
    int          n_status [5];

    function new();
      foreach (full[i]) begin
        full[i] = 1'b0;
        slot_len[i] = '0;
      end
      wslot = 0;
      rslot = 0;
      max_pay = 1500;
    endfunction

    function status_t fill_header(int unsigned base, int unsigned len);
      int unsigned ip;
      int unsigned hl;
      int unsigned sum;
      int unsigned i;
      ip = base + 14;
      if (len < 34) return ST_BAD_IP;
      hl = store[ip][3:0] * 4;
      if (hl < 20 || len < 14 + hl) return ST_BAD_IP;
      store[ip + 10] = 8'h00;
      store[ip + 11] = 8'h00;
      written[ip + 10] = 1'b1;
      written[ip + 11] = 1'b1;
      sum = 0;
      for (i = 0; i < hl; i += 2) begin
        sum += {store[ip + i], store[ip + i + 1]};
        if ((sum & 32'hFFFF_0000) != 0) sum = (sum & 32'hFFFF) + (sum >> 16);
      end
      sum = ~sum & 32'hFFFF;
      store[ip + 10] = sum[15:8];
      store[ip + 11] = sum[7:0];
      n_cksum++;
      return ST_OK;
    endfunction

    function ring_rsp_t note_request(ring_req_t req);
      ring_rsp_t rsp;
      int unsigned ws;
      int unsigned rs;
      status_t st;
      ws = wslot;
      rs = rslot;
      st = ST_OK;
      rsp.rbyte = 8'h00;
      rsp.irq = 1'b0;
      case (req.mode)
        MODE_WR_BYTE: begin
          if (full[ws]) begin
            st = ST_IGNORED;
          end else begin
            store[ws * SLOT_BYTES + req.off] = req.wbyte;
            written[ws * SLOT_BYTES + req.off] = 1'b1;
          end
        end
        MODE_COMMIT: begin
          if (req.len < 14) st = ST_SHORT;
          else if (req.len > max_pay + 14 || req.len > SLOT_BYTES) st = ST_LONG;
          else if (full[ws]) st = ST_IGNORED;
          else if (req.ipv4) st = fill_header(ws * SLOT_BYTES, req.len);
          if (st == ST_OK) begin
            slot_len[ws] = req.len;
            full[ws] = 1'b1;
            wslot = (ws + 1) % RING_SLOTS;
            rsp.irq = 1'b1;
            n_commits++;
          end
        end
        MODE_RD_BYTE: begin
          if (!full[rs]) st = ST_IGNORED;
          else rsp.rbyte = store[rs * SLOT_BYTES + req.off];
        end
        default: begin
          if (!full[rs]) begin
            st = ST_IGNORED;
          end else begin
            full[rs] = 1'b0;
            rslot = (rs + 1) % RING_SLOTS;
          end
        end
      endcase
      rsp.status = st;
      rsp.tx_free = !full[wslot];
      rsp.rx_ready = full[rslot];
      rsp.rx_len = full[rslot] ? slot_len[rslot] : 11'd0;
      pending.push_back(rsp);
      n_items++;
      n_status[st]++;
      return rsp;
    endfunction

    function void check_response(logic [31:0] d);
      ring_rsp_t exp_rsp;
      if (pending.size() == 0) begin
        $error("result 0x%08h arrived with no transaction outstanding", d);
        errors++;
        return;
      end
      exp_rsp = pending.pop_front();
      n_checked++;
      if (d[7:0] !== exp_rsp.rbyte) begin
        $error("read_byte: expected 0x%02h, got 0x%02h", exp_rsp.rbyte, d[7:0]);
        errors++;
      end
      if (d[8] !== exp_rsp.tx_free) begin
        $error("tx_slot_free: expected %0b, got %0b", exp_rsp.tx_free, d[8]);
        errors++;
      end
      if (d[9] !== exp_rsp.rx_ready) begin
        $error("rx_frame_ready: expected %0b, got %0b", exp_rsp.rx_ready, d[9]);
        errors++;
      end
      if (d[20:10] !== exp_rsp.rx_len) begin
        $error("rx_length: expected %0d, got %0d", exp_rsp.rx_len, d[20:10]);
        errors++;
      end
      if (d[23:21] !== exp_rsp.status) begin
        $error("status: expected %0d, got %0d", exp_rsp.status, d[23:21]);
        errors++;
      end
      if (d[24] !== exp_rsp.irq) begin
        $error("interrupt: expected %0b, got %0b", exp_rsp.irq, d[24]);
        errors++;
      end
    endfunction

    function bit tx_written(int unsigned off);
      return written[wslot * SLOT_BYTES + off];
    endfunction

    // An IPv4 commit that gets as far as the header must not sum bytes that
    // were never stored.
    function bit header_ready(int unsigned len, bit ipv4);
      int unsigned b;
      int unsigned hl;
      int unsigned i;
      b = wslot * SLOT_BYTES + 14;
      if (!ipv4) return 1'b1;
      if (len < 34 || len > max_pay + 14 || len > SLOT_BYTES || full[wslot]) return 1'b1;
      if (!written[b]) return 1'b0;
      hl = store[b][3:0] * 4;
      if (hl < 20 || len < 14 + hl) return 1'b1;
      for (i = 0; i < hl; i++)
        if (i != 10 && i != 11 && !written[b + i]) return 1'b0;
      return 1'b1;
    endfunction

    // Returns an offset that is safe to read in the receive slot, or -1.
    function int pick_read_offset();
      int unsigned b;
      int off;
      int k;
      b = rslot * SLOT_BYTES;
      if (!full[rslot]) return $urandom_range(0, SLOT_BYTES - 1);
      for (k = 0; k < 16; k++) begin
        off = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 80)
                                          : $urandom_range(0, SLOT_BYTES - 1);
        if (written[b + off]) return off;
      end
      off = $urandom_range(0, SLOT_BYTES - 1);
      for (k = 0; k < SLOT_BYTES; k++)
        if (written[b + (off + k) % SLOT_BYTES]) return (off + k) % SLOT_BYTES;
      return -1;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  frame_ring_board sb = new();
  bit calm = 1'b0;
  int stall_pct = 25;
  int n_cfg = 0;

  always #2 clk = ~clk;

  loopback_frame_ring_ipv4_checksum #(
    .RING_DEPTH(RING_SLOTS),
    .BUF_BYTES (SLOT_BYTES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Drives one transaction and returns once it has been accepted.
  task automatic send(input mode_t m, input int off, input int wb, input int len,
                      input bit v4, output status_t st);
    ring_req_t req;
    ring_rsp_t rsp;
    req.mode = m;
    req.off = off[10:0];
    req.wbyte = wb[7:0];
    req.len = len[10:0];
    req.ipv4 = v4;
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, req.ipv4, req.len, req.wbyte, req.off};
    in_tuser <= req.mode;
    do @(posedge clk); while (!in_tready);
    rsp = sb.note_request(req);
    st = rsp.status;
  endtask

  task automatic put_byte(input int off, input int val);
    status_t st;
    send(MODE_WR_BYTE, off, val, $urandom_range(0, 2047), $urandom_range(0, 1), st);
  endtask

  task automatic idle_in();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    idle_in();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_payload(input int unsigned v);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[10:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.max_pay = v;
    n_cfg++;
  endtask

  // Fills the transmit slot with a frame, mostly a well-formed IPv4 one,
  // and commits it.
  task automatic build_frame();
    int ihl;
    int hl;
    int len;
    int base_len;
    int r;
    int i;
    int n;
    bit v4;
    status_t st;
    v4 = $urandom_range(0, 9) < 7;
    r = $urandom_range(0, 99);
    ihl = (r < 70) ? 5 : (r < 90) ? $urandom_range(6, 15) : $urandom_range(0, 4);
    hl = ihl * 4;
    for (i = 0; i < 14; i++)
      if ($urandom_range(0, 3) == 0) put_byte(i, $urandom_range(0, 255));
    if (v4) begin
      put_byte(14, {4'h4, ihl[3:0]});
      for (i = 15; i < 14 + hl; i++)
        if (!sb.tx_written(i) || $urandom_range(0, 9) < 4) put_byte(i, $urandom_range(0, 255));
    end
    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) put_byte(14 + hl + $urandom_range(0, 63), $urandom_range(0, 255));
    base_len = v4 ? ((14 + hl > 34) ? 14 + hl : 34) : 14;
    r = $urandom_range(0, 99);
    if (r < 80) len = base_len + $urandom_range(0, 40);
    else if (r < 90) len = $urandom_range(base_len, 2047);
    else len = base_len - $urandom_range(1, 3);
    if (len > 2047) len = 2047;
    if (!sb.header_ready(len, v4)) v4 = 1'b0;
    send(MODE_COMMIT, $urandom_range(0, 2047), $urandom_range(0, 255), len, v4, st);
  endtask

  task automatic consume_frame();
    int n;
    int i;
    int off;
    status_t st;
    n = $urandom_range(1, 5);
    for (i = 0; i < n; i++) begin
      off = sb.pick_read_offset();
      if (off < 0) break;
      send(MODE_RD_BYTE, off, $urandom_range(0, 255), $urandom_range(0, 2047),
           $urandom_range(0, 1), st);
    end
    if ($urandom_range(0, 99) < 85)
      send(MODE_RELEASE, $urandom_range(0, 2047), $urandom_range(0, 255),
           $urandom_range(0, 2047), $urandom_range(0, 1), st);
  endtask

  task automatic noise_item();
    mode_t m;
    int off;
    int len;
    bit v4;
    status_t st;
    m = mode_t'($urandom_range(0, 3));
    off = $urandom_range(0, 2047);
    len = $urandom_range(0, 2047);
    v4 = $urandom_range(0, 1);
    if (m == MODE_RD_BYTE) begin
      off = sb.pick_read_offset();
      if (off < 0) begin
        m = MODE_RELEASE;
        off = $urandom_range(0, 2047);
      end
    end
    if (m == MODE_COMMIT && !sb.header_ready(len, v4)) v4 = 1'b0;
    send(m, off, $urandom_range(0, 255), len, v4, st);
  endtask

  // Result side: takes results under random back-pressure.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < stall_pct) hold = gap_len();
      end
    end
  end

  initial begin
    int unsigned pay_set [6];
    int build_pct [6];
    int phase;
    int r;
    status_t st;
    pay_set = '{1500, 2034, 0, 40, 0, 1500};
    build_pct = '{45, 70, 40, 50, 30, 55};
    pay_set[4] = $urandom_range(0, 2034);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty ring, length limits, bad IPv4 headers, field extremes.
    send(MODE_RD_BYTE, 0, 0, 0, 0, st);
    send(MODE_RELEASE, 2047, 255, 2047, 1, st);
    send(MODE_COMMIT, 0, 0, 0, 0, st);
    send(MODE_COMMIT, 0, 0, 13, 1, st);
    send(MODE_COMMIT, 0, 0, 1515, 0, st);
    send(MODE_COMMIT, 2047, 255, 2047, 1, st);
    put_byte(0, 8'hFF);
    put_byte(2047, 8'h00);
    put_byte(14, 8'h44);
    send(MODE_COMMIT, 0, 0, 34, 1, st);
    send(MODE_COMMIT, 0, 0, 33, 1, st);
    send(MODE_COMMIT, 0, 0, 14, 0, st);
    send(MODE_RD_BYTE, 0, 0, 0, 0, st);
    send(MODE_RD_BYTE, 2047, 0, 0, 0, st);
    send(MODE_COMMIT, 0, 0, 1514, 0, st);
    send(MODE_RELEASE, 0, 0, 0, 0, st);
    send(MODE_RELEASE, 0, 0, 0, 0, st);
    send(MODE_RELEASE, 0, 0, 0, 0, st);

    for (phase = 0; phase < 6; phase++) begin
      if (phase != 0) set_max_payload(pay_set[phase]);
      while (sb.n_items < (phase + 1) * 158) begin
        if ($urandom_range(0, 49) == 0) begin
          calm = !calm;
          stall_pct = calm ? 0 : 25;
        end
        if ($urandom_range(0, 99) == 0) wait_drain();
        r = $urandom_range(0, 99);
        if (r < build_pct[phase] && (sb.full[sb.wslot] == 1'b0 || $urandom_range(0, 3) == 0))
          build_frame();
        else if (r < 85) consume_frame();
        else noise_item();
      end
    end

    idle_in();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d transactions and %0d checked results: %0d frames committed,",
             sb.n_items, sb.n_checked, sb.n_commits);
    $display("%0d checksums inserted, %0d ignored, %0d short, %0d long,",
             sb.n_cksum, sb.n_status[ST_IGNORED], sb.n_status[ST_SHORT],
             sb.n_status[ST_LONG]);
    $display("%0d bad headers, %0d max_payload writes.",
             sb.n_status[ST_BAD_IP], n_cfg);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding.", sb.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
